[hw/rtl/ptc_pkg.sv]
package ptc_pkg;

  localparam int unsigned NumCalib = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CalibW   = 32;
  localparam int unsigned RawW     = 20;

  // restoring divider: 64-bit dividend, divisor magnitude up to 2^30
  localparam int unsigned DivW  = 64;
  localparam int unsigned DvsrW = 31;

  localparam logic [63:0] TempOffset = 64'd128000;
  localparam logic [63:0] PressBias  = 64'h0000_8000_0000_0000;  // 2^47
  localparam logic [20:0] RawFull    = 21'h10_0000;              // 2^20
  localparam logic [11:0] PressScale = 12'd3125;

  typedef enum logic [CfgIdxW-1:0] {
    REG_T1_T2 = 3'd0,
    REG_T3_P1 = 3'd1,
    REG_P2_P3 = 3'd2,
    REG_P4_P5 = 3'd3,
    REG_P6_P7 = 3'd4,
    REG_P8_P9 = 3'd5
  } ptc_reg_e;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } ptc_in_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } ptc_out_t;

  // temperature results and division flags that ride alongside the divider
  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] tcenti;
    logic        nz;
    logic        neg;
  } ptc_side_t;

endpackage

[hw/rtl/ptc_div.sv]
module ptc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [ptc_pkg::DivW-1:0]     num_i,
  input  logic [ptc_pkg::DvsrW-1:0]    den_i,
  input  ptc_pkg::ptc_side_t           side_i,
  output logic                         vld_o,
  output logic [ptc_pkg::DivW-1:0]     quo_o,
  output ptc_pkg::ptc_side_t           side_o
);
  import ptc_pkg::*;

  // one quotient bit per stage, msb first
  logic [DivW-1:0]  word_q [DivW];
  logic [DvsrW-1:0] rem_q  [DivW];
  logic [DvsrW-1:0] den_q  [DivW];
  ptc_side_t        side_q [DivW];
  logic [DivW-1:0]  vld_q;

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic [DivW-1:0]  word_in;
    logic [DvsrW-1:0] rem_in;
    logic [DvsrW-1:0] den_in;
    ptc_side_t        side_in;
    logic             vld_in;
    logic [DvsrW:0]   trial;
    logic [DvsrW:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign word_in = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign word_in = word_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = {rem_in, word_in[DivW-1]};
    assign ge    = (trial >= {1'b0, den_in});
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        word_q[k] <= {word_in[DivW-2:0], ge};
        rem_q[k]  <= ge ? diff[DvsrW-1:0] : trial[DvsrW-1:0];
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[DivW-1];
  assign quo_o  = word_q[DivW-1];
  assign side_o = side_q[DivW-1];

endmodule

[hw/rtl/pressure_temp_compensation_unit.sv]
// Barometric sensor compensation: each item carries one raw temperature and one raw
// pressure reading and yields the fine temperature term, the temperature in hundredths
// of a degree and the pressure in pascal as unsigned Q24.8 (pressure_valid low and
// pressure zero when the calibration gives a zero divisor). The unit is fully pipelined
// and takes one item every cycle while the output buffer is not full; an item passes
// through nine pre-division stages, a 64-stage restoring divider producing one quotient
// bit per stage and five post-division stages into the two-entry output buffer.
// The pipeline stalls only while that buffer is full. Calibration registers are
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i and must only change while the
// unit holds no items; indexes beyond the six registers are ignored.
module pressure_temp_compensation_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ptc_pkg::ptc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ptc_pkg::ptc_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ptc_pkg::CalibW-1:0]     cfg_wdata_i
);
  import ptc_pkg::*;

  // ---------------------------------------------------------------- calibration
  logic [CalibW-1:0] calib_q [NumCalib];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCalib; i++) begin
        calib_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_T1_T2: calib_q[0] <= cfg_wdata_i;
        REG_T3_P1: calib_q[1] <= cfg_wdata_i;
        REG_P2_P3: calib_q[2] <= cfg_wdata_i;
        REG_P4_P5: calib_q[3] <= cfg_wdata_i;
        REG_P6_P7: calib_q[4] <= cfg_wdata_i;
        REG_P8_P9: calib_q[5] <= cfg_wdata_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // coefficient fields
  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = calib_q[0][15:0];
  assign t2 = $signed(calib_q[0][31:16]);
  assign t3 = $signed(calib_q[1][15:0]);
  assign p1 = calib_q[1][31:16];
  assign p2 = $signed(calib_q[2][15:0]);
  assign p3 = $signed(calib_q[2][31:16]);
  assign p4 = $signed(calib_q[3][15:0]);
  assign p5 = $signed(calib_q[3][31:16]);
  assign p6 = $signed(calib_q[4][15:0]);
  assign p7 = $signed(calib_q[4][31:16]);
  assign p8 = $signed(calib_q[5][15:0]);
  assign p9 = $signed(calib_q[5][31:16]);

  // sign-extended copies for products that only need the low 32 bits
  logic [31:0] p3x, p6x, p8x, p9x;
  assign p3x = {{16{p3[15]}}, p3};
  assign p6x = {{16{p6[15]}}, p6};
  assign p8x = {{16{p8[15]}}, p8};
  assign p9x = {{16{p9[15]}}, p9};

  // ---------------------------------------------------------------- flow control
  // whole datapath advances together; only a full output buffer holds it
  logic       adv;
  logic [1:0] cnt_q;
  logic [8:0] pre_vld_q;
  logic [4:0] post_vld_q;
  logic       div_vld;

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q  <= '0;
      post_vld_q <= '0;
    end else if (adv) begin
      pre_vld_q  <= {pre_vld_q[7:0], in_valid_i};
      post_vld_q <= {post_vld_q[3:0], div_vld};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // temperature differences and their products
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] m1, sq;
  assign d1 = $signed({1'b0, in_data_i.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2 = $signed({1'b0, in_data_i.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign m1 = d1 * t2;
  assign sq = d2 * d2;

  logic [31:0]     s1_m1_q, s1_sq_q;
  logic [RawW-1:0] s1_adcp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_m1_q   <= m1[31:0];
      s1_sq_q   <= sq[31:0];
      s1_adcp_q <= in_data_i.raw_pressure;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [31:0] tv1, sqs;
  logic signed [19:0] sq20;
  logic signed [35:0] m3;
  assign tv1  = $signed(s1_m1_q) >>> 11;
  assign sqs  = $signed(s1_sq_q) >>> 12;
  assign sq20 = sqs[19:0];
  assign m3   = sq20 * t3;

  logic [31:0]     s2_tv1_q, s2_m3_q;
  logic [RawW-1:0] s2_adcp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_tv1_q  <= tv1;
      s2_m3_q   <= m3[31:0];
      s2_adcp_q <= s1_adcp_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [31:0] tv2;
  logic        [31:0] fine;
  assign tv2  = $signed(s2_m3_q) >>> 14;
  assign fine = s2_tv1_q + tv2;

  logic [31:0]     s3_fine_q;
  logic [RawW-1:0] s3_adcp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_fine_q <= fine;
      s3_adcp_q <= s2_adcp_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // centi-degrees, and the offset temperature with its products
  logic        [31:0] f5;
  logic signed [31:0] tc;
  logic signed [32:0] sv;
  logic signed [65:0] ss;
  logic signed [48:0] sp5, sp2;
  assign f5  = s3_fine_q + (s3_fine_q << 2);
  assign tc  = $signed(f5 + 32'd128) >>> 8;
  assign sv  = $signed({s3_fine_q[31], s3_fine_q}) - $signed(TempOffset[32:0]);
  assign ss  = sv * sv;
  assign sp5 = sv * p5;
  assign sp2 = sv * p2;

  logic [31:0]     s4_fine_q, s4_tc_q;
  logic [63:0]     s4_ss_q;
  logic [48:0]     s4_sp5_q, s4_sp2_q;
  logic [RawW-1:0] s4_adcp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_fine_q <= s3_fine_q;
      s4_tc_q   <= tc;
      s4_ss_q   <= ss[63:0];
      s4_sp5_q  <= sp5;
      s4_sp2_q  <= sp2;
      s4_adcp_q <= s3_adcp_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // square times p6 and p3, split into low and high partial products
  logic signed [32:0] ss_lo;
  logic signed [48:0] a6l, a3l;
  logic        [31:0] a6h, a3h;
  assign ss_lo = $signed({1'b0, s4_ss_q[31:0]});
  assign a6l   = ss_lo * p6;
  assign a3l   = ss_lo * p3;
  assign a6h   = s4_ss_q[63:32] * p6x;
  assign a3h   = s4_ss_q[63:32] * p3x;

  logic [31:0]     s5_fine_q, s5_tc_q, s5_a6h_q, s5_a3h_q;
  logic [48:0]     s5_a6l_q, s5_a3l_q, s5_sp5_q, s5_sp2_q;
  logic [RawW-1:0] s5_adcp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_fine_q <= s4_fine_q;
      s5_tc_q   <= s4_tc_q;
      s5_a6l_q  <= a6l;
      s5_a6h_q  <= a6h;
      s5_a3l_q  <= a3l;
      s5_a3h_q  <= a3h;
      s5_sp5_q  <= s4_sp5_q;
      s5_sp2_q  <= s4_sp2_q;
      s5_adcp_q <= s4_adcp_q;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic        [63:0] a6, a3, v2, v1b;
  logic signed [63:0] a3s;
  assign a6  = {{15{s5_a6l_q[48]}}, s5_a6l_q} + {s5_a6h_q, 32'b0};
  assign a3  = {{15{s5_a3l_q[48]}}, s5_a3l_q} + {s5_a3h_q, 32'b0};
  assign a3s = $signed(a3) >>> 8;
  assign v2  = a6 + ({{15{s5_sp5_q[48]}}, s5_sp5_q} << 17) + ({{48{p4[15]}}, p4} << 35);
  assign v1b = a3s + ({{15{s5_sp2_q[48]}}, s5_sp2_q} << 12);

  logic [31:0]     s6_fine_q, s6_tc_q;
  logic [63:0]     s6_v2_q, s6_v1b_q;
  logic [RawW-1:0] s6_adcp_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_fine_q <= s5_fine_q;
      s6_tc_q   <= s5_tc_q;
      s6_v2_q   <= v2;
      s6_v1b_q  <= v1b;
      s6_adcp_q <= s5_adcp_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // divisor and dividend partial products
  logic [63:0] xb, nn;
  logic [20:0] pn;
  logic [47:0] xl;
  logic [31:0] xh, nh;
  logic [43:0] nl;
  assign xb = PressBias + s6_v1b_q;
  assign xl = xb[31:0] * p1;
  assign xh = xb[63:32] * {16'b0, p1};
  assign pn = RawFull - {1'b0, s6_adcp_q};
  assign nn = ({43'b0, pn} << 31) - s6_v2_q;
  assign nl = nn[31:0] * PressScale;
  assign nh = nn[63:32] * {20'b0, PressScale};

  logic [31:0] s7_fine_q, s7_tc_q, s7_xh_q, s7_nh_q;
  logic [47:0] s7_xl_q;
  logic [43:0] s7_nl_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_fine_q <= s6_fine_q;
      s7_tc_q   <= s6_tc_q;
      s7_xl_q   <= xl;
      s7_xh_q   <= xh;
      s7_nl_q   <= nl;
      s7_nh_q   <= nh;
    end
  end

  // ---------------------------------------------------------------- stage 8
  logic [63:0] pr1, num;
  assign pr1 = {16'b0, s7_xl_q} + {s7_xh_q, 32'b0};
  assign num = {20'b0, s7_nl_q} + {s7_nh_q, 32'b0};

  logic [31:0]      s8_fine_q, s8_tc_q;
  logic [63:0]      s8_num_q;
  logic [DvsrW-1:0] s8_div_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_fine_q <= s7_fine_q;
      s8_tc_q   <= s7_tc_q;
      s8_num_q  <= num;
      s8_div_q  <= pr1[63:33];
    end
  end

  // ---------------------------------------------------------------- stage 9
  // magnitudes and sign for the unsigned divider
  ptc_side_t        side9;
  logic [DivW-1:0]  num_abs;
  logic [DvsrW-1:0] div_abs;
  assign num_abs      = s8_num_q[63] ? (64'd0 - s8_num_q) : s8_num_q;
  assign div_abs      = s8_div_q[DvsrW-1] ? ({DvsrW{1'b0}} - s8_div_q) : s8_div_q;
  assign side9.fine   = s8_fine_q;
  assign side9.tcenti = s8_tc_q;
  assign side9.nz     = |s8_div_q;
  assign side9.neg    = s8_num_q[63] ^ s8_div_q[DvsrW-1];

  ptc_side_t        s9_side_q;
  logic [DivW-1:0]  s9_num_q;
  logic [DvsrW-1:0] s9_div_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_side_q <= side9;
      s9_num_q  <= num_abs;
      s9_div_q  <= div_abs;
    end
  end

  // ---------------------------------------------------------------- divider
  logic [DivW-1:0] quo;
  ptc_side_t       div_side;

  ptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (pre_vld_q[8]),
    .num_i  (s9_num_q),
    .den_i  (s9_div_q),
    .side_i (s9_side_q),
    .vld_o  (div_vld),
    .quo_o  (quo),
    .side_o (div_side)
  );

  // ---------------------------------------------------------------- post 1
  logic [63:0] e1_p_q;
  ptc_side_t   e1_side_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_p_q    <= div_side.neg ? (64'd0 - quo) : quo;
      e1_side_q <= div_side;
    end
  end

  // ---------------------------------------------------------------- post 2
  // ps squared and p times p8, as partial products
  logic signed [63:0] ps;
  logic        [63:0] psu, ll;
  logic        [31:0] lh, w2h;
  logic signed [48:0] w2l;
  assign ps  = $signed(e1_p_q) >>> 13;
  assign psu = ps;
  assign ll  = psu[31:0] * psu[31:0];
  assign lh  = psu[31:0] * psu[63:32];
  assign w2l = $signed({1'b0, e1_p_q[31:0]}) * p8;
  assign w2h = e1_p_q[63:32] * p8x;

  logic [63:0] e2_p_q, e2_ll_q;
  logic [31:0] e2_lh_q, e2_w2h_q;
  logic [48:0] e2_w2l_q;
  ptc_side_t   e2_side_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e2_p_q    <= e1_p_q;
      e2_ll_q   <= ll;
      e2_lh_q   <= lh;
      e2_w2l_q  <= w2l;
      e2_w2h_q  <= w2h;
      e2_side_q <= e1_side_q;
    end
  end

  // ---------------------------------------------------------------- post 3
  logic        [63:0] pp, w2s;
  logic signed [63:0] w2;
  assign pp  = e2_ll_q + {e2_lh_q[30:0], 1'b0, 32'b0};
  assign w2s = {{15{e2_w2l_q[48]}}, e2_w2l_q} + {e2_w2h_q, 32'b0};
  assign w2  = $signed(w2s) >>> 19;

  logic [63:0] e3_p_q, e3_pp_q, e3_w2_q;
  ptc_side_t   e3_side_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e3_p_q    <= e2_p_q;
      e3_pp_q   <= pp;
      e3_w2_q   <= w2;
      e3_side_q <= e2_side_q;
    end
  end

  // ---------------------------------------------------------------- post 4
  logic signed [48:0] pl9;
  logic        [31:0] ph9;
  assign pl9 = $signed({1'b0, e3_pp_q[31:0]}) * p9;
  assign ph9 = e3_pp_q[63:32] * p9x;

  logic [63:0] e4_p_q, e4_w2_q;
  logic [48:0] e4_pl9_q;
  logic [31:0] e4_ph9_q;
  ptc_side_t   e4_side_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e4_p_q    <= e3_p_q;
      e4_w2_q   <= e3_w2_q;
      e4_pl9_q  <= pl9;
      e4_ph9_q  <= ph9;
      e4_side_q <= e3_side_q;
    end
  end

  // ---------------------------------------------------------------- post 5
  logic        [63:0] w1s;
  logic signed [63:0] w1;
  assign w1s = {{15{e4_pl9_q[48]}}, e4_pl9_q} + {e4_ph9_q, 32'b0};
  assign w1  = $signed(w1s) >>> 25;

  logic [63:0] e5_pw_q, e5_w1_q;
  ptc_side_t   e5_side_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e5_pw_q   <= e4_p_q + e4_w2_q;
      e5_w1_q   <= w1;
      e5_side_q <= e4_side_q;
    end
  end

  // ---------------------------------------------------------------- final sum
  logic        [63:0] psum, pres;
  logic signed [63:0] psh;
  ptc_out_t           res;
  assign psum = e5_pw_q + e5_w1_q;
  assign psh  = $signed(psum) >>> 8;
  assign pres = psh + ({{48{p7[15]}}, p7} << 4);

  assign res.fine_temperature  = $signed(e5_side_q.fine);
  assign res.temperature_centi = $signed(e5_side_q.tcenti);
  assign res.pressure_q24_8    = e5_side_q.nz ? pres[31:0] : 32'd0;
  assign res.pressure_valid    = e5_side_q.nz;

  // ---------------------------------------------------------------- output buffer
  logic     push, pop;
  logic     wr_q, rd_q;
  ptc_out_t buf_q [2];

  assign push        = adv && post_vld_q[4];
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res;
    end
  end

  // ---------------------------------------------------------------- checks
  // buffer never holds more than two items
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  // a zero divisor must always come out as zero pressure
  a_zero_press : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pressure_valid |-> out_data_o.pressure_q24_8 == 32'd0)
    else $error("pressure not cleared on zero divisor");

  // a stalled pipeline keeps its pre- and post-division valid bits in place
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(post_vld_q) && $stable(pre_vld_q))
    else $error("pipeline moved during stall");

endmodule
